// File: hw/rtl/kae_pkg.sv
// kae_pkg: shared types and constants for the key auto-repeat engine
// no dependencies; imported by kae_cfg, kae_core and key_autorepeat_engine
package kae_pkg;

  localparam int NUM_KEYS    = 256;
  localparam int KEY_W       = 8;
  localparam int KEY_AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int SAMPLE_W    = 16;
  localparam int TIME_W      = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;
  localparam int EVENT_W     = 2;

  localparam int DELAY_W     = 10;
  localparam int INTERVAL_W  = 9;
  localparam int THRESH_W    = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;

  localparam logic [DELAY_W-1:0]    DELAY_RESET    = DELAY_W'(250);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(33);
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL   = INTERVAL_W'(10);
  localparam logic [THRESH_W-1:0]   THRESH_RESET   = THRESH_W'(328);

  localparam logic [CFG_IDX_W-1:0] REG_DELAY     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(2);

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_REPEAT  = 2'd2,
    EV_RELEASE = 2'd3
  } key_event_t;

  typedef struct packed {
    logic [DELAY_W-1:0]    repeat_delay_ms;
    logic [INTERVAL_W-1:0] repeat_interval_ms;
    logic [THRESH_W-1:0]   active_threshold;
  } kae_cfg_t;

endpackage

// File: hw/rtl/kae_ram.sv
// kae_ram: generic single-port-write, single-port-read synchronous ram
// registered read, old data on a read of the address being written; no dependencies
module kae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/kae_cfg.sv
// kae_cfg: configuration registers of the key auto-repeat engine
// depends on kae_pkg; interval writes below the minimum are clamped
module kae_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kae_pkg::CFG_DATA_W-1:0] cfg_data,
  output kae_pkg::kae_cfg_t              cfg
);
  import kae_pkg::*;

  logic [INTERVAL_W-1:0] interval_wr;

  assign cfg_ready   = 1'b1;
  assign interval_wr = (cfg_data[INTERVAL_W-1:0] < MIN_INTERVAL) ? MIN_INTERVAL
                                                                 : cfg_data[INTERVAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_delay_ms    <= DELAY_RESET;
      cfg.repeat_interval_ms <= INTERVAL_RESET;
      cfg.active_threshold   <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELAY:     cfg.repeat_delay_ms    <= cfg_data[DELAY_W-1:0];
        REG_INTERVAL:  cfg.repeat_interval_ms <= interval_wr;
        REG_THRESHOLD: cfg.active_threshold   <= cfg_data[THRESH_W-1:0];
        default:       ;
      endcase
    end
  end

endmodule

// File: hw/rtl/kae_core.sv
// kae_core: per-key read-modify-write pipeline with due-time ram and held flags
// depends on kae_pkg and kae_ram
module kae_core (
  input  logic                            clk,
  input  logic                            rst,
  input  kae_pkg::kae_cfg_t               cfg,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key_index[7:0], sample_value[23:8], time_ms[55:24]
  input  logic [kae_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // event_key[7:0]
  output logic [kae_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // key_event[1:0]
  output logic [kae_pkg::EVENT_W-1:0]     m_axis_tuser
);
  import kae_pkg::*;

  // input side decode
  logic [KEY_W-1:0]    in_key;
  logic [SAMPLE_W-1:0] in_sample;
  logic [TIME_W-1:0]   in_now;
  logic [SAMPLE_W-1:0] in_mag;
  logic                in_want;
  logic                in_range;
  logic [KEY_AW-1:0]   in_addr;
  logic                s_accept;

  // stage 1: item waiting on its ram read
  logic                s1_valid;
  logic [KEY_W-1:0]    s1_key;
  logic [KEY_AW-1:0]   s1_addr;
  logic                s1_range;
  logic                s1_want;
  logic                s1_held;
  logic [TIME_W-1:0]   s1_now;
  logic [TIME_W-1:0]   s1_due_press;
  logic [TIME_W-1:0]   s1_due_repeat;
  logic                s1_adv;

  logic [NUM_KEYS-1:0] held;
  logic                held_cur;
  logic [TIME_W-1:0]   ram_rdata;
  logic                fwd_valid;
  logic [TIME_W-1:0]   fwd_data;
  logic [TIME_W-1:0]   due_cur;
  logic [TIME_W-1:0]   elapsed;
  logic                reached;
  key_event_t          ev;
  logic [TIME_W-1:0]   due_next;
  logic                ram_we;

  logic                out_valid;
  key_event_t          out_event;
  logic [KEY_W-1:0]    out_key;

  assign in_key    = s_axis_tdata[KEY_W-1:0];
  assign in_sample = s_axis_tdata[KEY_W +: SAMPLE_W];
  assign in_now    = s_axis_tdata[KEY_W+SAMPLE_W +: TIME_W];
  // magnitude of -32768 comes out as 0x8000, above any threshold
  assign in_mag    = in_sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - in_sample) : in_sample;
  assign in_want   = in_mag > {1'b0, cfg.active_threshold};
  assign in_range  = {1'b0, in_key} < (KEY_W+1)'(NUM_KEYS);
  assign in_addr   = KEY_AW'(in_key);

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_key        <= in_key;
      s1_addr       <= in_addr;
      s1_range      <= in_range;
      s1_want       <= in_want;
      s1_now        <= in_now;
      s1_due_press  <= in_now + TIME_W'(cfg.repeat_delay_ms);
      s1_due_repeat <= in_now + TIME_W'(cfg.repeat_interval_ms);
      // held flag read is registered, with the update of the leaving item forwarded
      if (s1_adv && (s1_addr == in_addr) && (ev == EV_PRESS)) begin
        s1_held <= 1'b1;
      end else if (s1_adv && (s1_addr == in_addr) && (ev == EV_RELEASE)) begin
        s1_held <= 1'b0;
      end else begin
        s1_held <= held[in_addr];
      end
    end
  end

  kae_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_KEYS)
  ) u_due_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (due_next),
    .re    (s_accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // the ram returns old data when the next item reads the entry written this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s_axis_tready) begin
      fwd_valid <= s_accept && ram_we && (in_addr == s1_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      fwd_data <= due_next;
    end
  end

  assign due_cur  = fwd_valid ? fwd_data : ram_rdata;
  assign held_cur = s1_range && s1_held;
  assign elapsed  = s1_now - due_cur;
  assign reached  = !elapsed[TIME_W-1];

  always_comb begin
    ev       = EV_NONE;
    due_next = s1_due_press;
    if (s1_range) begin
      if (s1_want && !held_cur) begin
        ev = EV_PRESS;
      end else if (s1_want) begin
        if (reached) begin
          ev       = EV_REPEAT;
          due_next = s1_due_repeat;
        end
      end else if (held_cur) begin
        ev = EV_RELEASE;
      end
    end
  end

  assign ram_we = s1_adv && ((ev == EV_PRESS) || (ev == EV_REPEAT));

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (s1_adv && (ev == EV_PRESS)) begin
      held[s1_addr] <= 1'b1;
    end else if (s1_adv && (ev == EV_RELEASE)) begin
      held[s1_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_event <= ev;
      out_key   <= s1_key;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_key;
  assign m_axis_tuser  = out_event;

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> s1_valid)
    else $error("forwarded due time without an item in stage 1");

  a_press_sets_held: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(s1_adv) && ($past(ev) == EV_PRESS)) |-> held[$past(s1_addr)])
    else $error("press did not mark the key held");

  a_release_clears_held: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (ev == EV_RELEASE)) |=> !held[$past(s1_addr)])
    else $error("release did not clear the held flag");

  a_no_press_when_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && held_cur) |-> (ev != EV_PRESS))
    else $error("press issued for a key already held");

endmodule

// File: hw/rtl/key_autorepeat_engine.sv
// key_autorepeat_engine: per-key typematic press, repeat and release events
// an input transaction passes stage 1 (due-time ram read) and then the output register
// throughput: one transaction per cycle while the output is not held off; the due-time ram read is registered,
// same-key updates of back-to-back transactions are forwarded around the ram
// reset: all keys released, registers back to delay 250, interval 33, threshold 328
// depends on kae_pkg, kae_cfg, kae_core
module key_autorepeat_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kae_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kae_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key_index[7:0], sample_value[23:8], time_ms[55:24]
  input  logic [kae_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // event_key[7:0]
  output logic [kae_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // key_event[1:0]
  output logic [kae_pkg::EVENT_W-1:0]     m_axis_tuser
);
  import kae_pkg::*;

  kae_cfg_t cfg;

  kae_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kae_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: verif/key_autorepeat_engine_test.sv
// key_autorepeat_engine_test: self-checking bench for the typematic engine, with press,
// repeat and release prediction per key, random stalls on both streams, register phases
// depends on kae_pkg and key_autorepeat_engine from hw/rtl
module key_autorepeat_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kae_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  // per-key typematic prediction and in-order event matching
  class typematic_scoreboard;
    typedef struct {
      key_event_t     ev;
      logic [KEY_W-1:0] key;
    } key_result_t;

    logic [DELAY_W-1:0]    rpt_delay;
    logic [INTERVAL_W-1:0] rpt_interval;
    logic [THRESH_W-1:0]   threshold;
    bit                    held [NUM_KEYS];
    logic [TIME_W-1:0]     due_ms [NUM_KEYS];
    key_result_t           expected_events [$];
    int                    errors;

    function new();
      rpt_delay    = DELAY_RESET;
      rpt_interval = INTERVAL_RESET;
      threshold    = THRESH_RESET;
      foreach (held[i]) begin
        held[i]   = 1'b0;
        due_ms[i] = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DELAY: begin
          rpt_delay = data[DELAY_W-1:0];
        end
        REG_INTERVAL: begin
          rpt_interval = (data[INTERVAL_W-1:0] < MIN_INTERVAL) ? MIN_INTERVAL
                                                               : data[INTERVAL_W-1:0];
        end
        REG_THRESHOLD: begin
          threshold = data[THRESH_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function void predict_event(logic [KEY_W-1:0] key, logic [SAMPLE_W-1:0] sample,
                                logic [TIME_W-1:0] now);
      logic [16:0]       mag;
      logic [TIME_W-1:0] since_due;
      bit                want;
      key_result_t       res;
      res.ev  = EV_NONE;
      res.key = key;
      // -32768 has magnitude 32768, above any threshold
      mag  = sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
      want = mag > {2'b00, threshold};
      if (int'(key) < NUM_KEYS) begin
        if (want && !held[key]) begin
          held[key]   = 1'b1;
          due_ms[key] = now + TIME_W'(rpt_delay);
          res.ev      = EV_PRESS;
        end else if (want) begin
          since_due = now - due_ms[key];
          // wrap-safe: due time reached when the difference is below half the range
          if (!since_due[TIME_W-1]) begin
            due_ms[key] = now + TIME_W'(rpt_interval);
            res.ev      = EV_REPEAT;
          end
        end else if (held[key]) begin
          held[key] = 1'b0;
          res.ev    = EV_RELEASE;
        end
      end
      expected_events.insert(expected_events.size(), res);
    endfunction

    function void check_event(key_event_t ev, logic [KEY_W-1:0] key);
      key_result_t exp_res;
      if (expected_events.size() == 0) begin
        $error("unexpected result: key_event %0d event_key %0d", ev, key);
        errors++;
        return;
      end
      exp_res = expected_events.pop_front();
      if (ev !== exp_res.ev) begin
        $error("key_event mismatch: expected %0d, actual %0d", exp_res.ev, ev);
        errors++;
      end
      if (key !== exp_res.key) begin
        $error("event_key mismatch: expected %0d, actual %0d", exp_res.key, key);
        errors++;
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [EVENT_W-1:0]     m_axis_tuser;

  typematic_scoreboard sb;
  bit                  src_idle_en;
  bit                  sink_idle_en;
  bit                  sink_hold_req;
  logic [TIME_W-1:0]   clock_ms;
  int                  cycle_count;

  key_autorepeat_engine u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] make_sample(bit wanted, logic [THRESH_W-1:0] th);
    int unsigned m;
    m = wanted ? $urandom_range(int'(th) + 1, 32768) : $urandom_range(0, int'(th));
    if (m == 32768) return 16'h8000;
    if ($urandom_range(0, 1) == 1) return SAMPLE_W'(-int'(m));
    return SAMPLE_W'(m);
  endfunction

  // result side: tready with random gaps, one long hold on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        sink_hold_req = 1'b0;
      end else begin
        gap = sink_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_event(key_event_t'(m_axis_tuser), m_axis_tdata[KEY_W-1:0]);
    end
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_key_sample(input logic [KEY_W-1:0] key,
                                 input logic [SAMPLE_W-1:0] sample,
                                 input logic [TIME_W-1:0] now);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, sample, key};
    do @(posedge clk); while (!s_axis_tready);
    sb.predict_event(key, sample, now);
    @(negedge clk);
  endtask

  task automatic wait_events_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_registers(input int delay, input int interval, input int thr);
    wait_events_drained();
    write_register(REG_DELAY, CFG_DATA_W'(delay));
    write_register(REG_INTERVAL, CFG_DATA_W'(interval));
    write_register(REG_THRESHOLD, CFG_DATA_W'(thr));
  endtask

  // mostly held keys from a small pool with time moving forward, plus noise
  task automatic run_typematic_traffic(input int n_items, input bit pause_midway);
    logic [KEY_W-1:0]    key_pool [4];
    logic [KEY_W-1:0]    k;
    logic [SAMPLE_W-1:0] s;
    logic [TIME_W-1:0]   t;
    int                  r;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 255));
    for (int i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) wait_events_drained();
      r = $urandom_range(0, 99);
      if (r < 80) begin
        k = key_pool[$urandom_range(0, 3)];
        clock_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1100)
                                                : $urandom_range(0, 40);
        s = make_sample($urandom_range(0, 3) != 0, sb.threshold);
        t = clock_ms;
      end else if (r < 95) begin
        k = KEY_W'($urandom_range(0, 255));
        s = SAMPLE_W'($urandom_range(0, 65535));
        t = clock_ms;
      end else begin
        k = KEY_W'($urandom_range(0, 255));
        s = SAMPLE_W'($urandom_range(0, 65535));
        t = $urandom();
      end
      send_key_sample(k, s, t);
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    sink_hold_req = 1'b0;
    clock_ms      = '0;
    cycle_count   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: delay 250, interval 33, threshold 328
    send_key_sample(8'd0, 16'h8000, 32'd0);
    send_key_sample(8'd0, 16'd329, 32'd249);
    send_key_sample(8'd0, 16'd329, 32'd250);
    send_key_sample(8'd0, 16'd32767, 32'd282);
    send_key_sample(8'd0, 16'd32767, 32'd283);
    send_key_sample(8'd0, 16'd328, 32'd300);
    send_key_sample(8'd0, SAMPLE_W'(-328), 32'd301);
    // due time wraps past zero, then the half-range boundary
    send_key_sample(8'd255, 16'd329, 32'hFFFF_FF00);
    send_key_sample(8'd255, SAMPLE_W'(-329), 32'h0000_00FA);
    send_key_sample(8'd255, SAMPLE_W'(-329), 32'h8000_011B);
    send_key_sample(8'd255, SAMPLE_W'(-329), 32'h8000_011A);
    send_key_sample(8'd255, 16'd0, 32'h8000_0200);

    // zero threshold and delay, interval below minimum clamps
    set_registers(0, 5, 0);
    send_key_sample(8'd1, 16'd1, 32'd100);
    send_key_sample(8'd1, 16'd1, 32'd100);
    send_key_sample(8'd1, 16'hFFFF, 32'd109);
    send_key_sample(8'd1, 16'hFFFF, 32'd110);
    send_key_sample(8'd1, 16'd0, 32'd111);

    // masked writes, top threshold, unused register index
    set_registers(16'h7FFF, 16'h0200, 16'h7FFF);
    write_register(REG_UNUSED, 15'h7FFF);
    send_key_sample(8'd2, 16'd32767, 32'hFFFF_FFFF);
    send_key_sample(8'd2, 16'h8000, 32'hFFFF_FFFF);
    send_key_sample(8'd2, 16'h8000, 32'h0000_03FD);
    send_key_sample(8'd2, 16'h8000, 32'h0000_03FE);
    send_key_sample(8'd2, 16'h8001, 32'h0000_0400);

    set_registers(1000, 400, 32767);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    clock_ms     = $urandom();
    run_typematic_traffic(120, 1'b1);

    // fast repeats, back to back, output held off so the input stalls
    set_registers(250, 10, 0);
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    sink_hold_req = 1'b1;
    run_typematic_traffic(115, 1'b0);

    set_registers(0, 5, 100);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    clock_ms     = 32'hFFFF_F000;
    run_typematic_traffic(115, 1'b0);

    set_registers(1023, 511, $urandom_range(0, 32767));
    sink_idle_en = 1'b0;
    clock_ms     = $urandom();
    run_typematic_traffic(115, 1'b0);

    set_registers($urandom_range(250, 1000), $urandom_range(10, 400),
                  $urandom_range(0, 32767));
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b1;
    clock_ms     = $urandom();
    run_typematic_traffic(115, 1'b0);

    wait_events_drained();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: key_autorepeat_engine.f
hw/rtl/kae_pkg.sv
hw/rtl/kae_ram.sv
hw/rtl/kae_cfg.sv
hw/rtl/kae_core.sv
hw/rtl/key_autorepeat_engine.sv
verif/key_autorepeat_engine_test.sv
